// File: sv/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB pixel pipeline.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

    localparam int unsigned ChanW  = 16;   // fixed point channel, max 32768
    localparam int unsigned PixW   = 8;    // 8-bit color components
    localparam int unsigned OffW   = 7;    // sector offset 0..85
    localparam int unsigned StepW  = 10;   // ramp step width
    localparam int unsigned DataW  = 24;   // three packed 8-bit fields

    localparam logic [7:0]        SectorB1  = 8'd86;
    localparam logic [7:0]        SectorB2  = 8'd171;
    localparam logic [7:0]        Base1     = 8'd85;
    localparam logic [7:0]        Base2     = 8'd170;
    localparam logic [OffW-1:0]   SectorLen = 7'd85;
    localparam logic [StepW-1:0]  RampStep  = 10'd771;
    localparam logic [ChanW-1:0]  ChanClamp = 16'd32768;
    localparam logic [7:0]        ValMid    = 8'd128;

    typedef logic [ChanW-1:0] chan_t;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
    } chan_set_t;

    // Payload after the hue ramp stage
    typedef struct packed {
        chan_set_t  chan;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } ramp_out_t;

    // Payload after the saturation blend stage
    typedef struct packed {
        chan_set_t  chan;
        logic [7:0] brightness;
    } sat_out_t;

    typedef struct packed {
        logic [PixW-1:0] red;
        logic [PixW-1:0] green;
        logic [PixW-1:0] blue;
    } rgb_t;

endpackage

`default_nettype wire

// File: sv/hsv2rgb_ramp.sv
// Stage 1: hue sector decode, ramp multiply and clamp.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_ramp (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             hue,
    input  wire logic [7:0]             saturation,
    input  wire logic [7:0]             brightness,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output hsv2rgb_pkg::ramp_out_t      out_data
);

    logic                        valid_reg;
    hsv2rgb_pkg::ramp_out_t      data_reg;
    hsv2rgb_pkg::ramp_out_t      data_next;
    logic [1:0]                  sector;
    logic [7:0]                  off_full;
    logic [hsv2rgb_pkg::OffW-1:0] off;
    logic [hsv2rgb_pkg::OffW-1:0] off_inv;
    logic [hsv2rgb_pkg::OffW+hsv2rgb_pkg::StepW-1:0] rise_prod;
    logic [hsv2rgb_pkg::OffW+hsv2rgb_pkg::StepW-1:0] fall_prod;
    hsv2rgb_pkg::chan_t          rise;
    hsv2rgb_pkg::chan_t          fall;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    function automatic hsv2rgb_pkg::chan_t clamp_chan(
        input logic [hsv2rgb_pkg::OffW+hsv2rgb_pkg::StepW-1:0] v
    );
        if (v > {1'b0, hsv2rgb_pkg::ChanClamp}) begin
            return hsv2rgb_pkg::ChanClamp;
        end
        return v[hsv2rgb_pkg::ChanW-1:0];
    endfunction

    always_comb begin
        if (hue < hsv2rgb_pkg::SectorB1) begin
            sector   = 2'd0;
            off_full = hue;
        end else if (hue < hsv2rgb_pkg::SectorB2) begin
            sector   = 2'd1;
            off_full = hue - hsv2rgb_pkg::Base1;
        end else begin
            sector   = 2'd2;
            off_full = hue - hsv2rgb_pkg::Base2;
        end
        off       = off_full[hsv2rgb_pkg::OffW-1:0];
        off_inv   = hsv2rgb_pkg::SectorLen - off;
        rise_prod = {{hsv2rgb_pkg::StepW{1'b0}}, off}
                  * {{hsv2rgb_pkg::OffW{1'b0}}, hsv2rgb_pkg::RampStep};
        fall_prod = {{hsv2rgb_pkg::StepW{1'b0}}, off_inv}
                  * {{hsv2rgb_pkg::OffW{1'b0}}, hsv2rgb_pkg::RampStep};
        rise      = clamp_chan(rise_prod);
        fall      = clamp_chan(fall_prod);

        data_next.saturation = saturation;
        data_next.brightness = brightness;
        case (sector)
            2'd0: begin
                data_next.chan.r = fall;
                data_next.chan.g = rise;
                data_next.chan.b = '0;
            end
            2'd1: begin
                data_next.chan.r = '0;
                data_next.chan.g = fall;
                data_next.chan.b = rise;
            end
            default: begin
                data_next.chan.r = rise;
                data_next.chan.g = '0;
                data_next.chan.b = fall;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/hsv2rgb_sat.sv
// Stage 2: saturation blend of each channel toward grey.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_sat (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire hsv2rgb_pkg::ramp_out_t in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output hsv2rgb_pkg::sat_out_t       out_data
);

    logic                   valid_reg;
    hsv2rgb_pkg::sat_out_t  data_reg;
    hsv2rgb_pkg::sat_out_t  data_next;
    logic [8:0]             sat_inv;
    logic [14:0]            grey;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // floor(c * s / 256) + (256 - s) * 64
    function automatic hsv2rgb_pkg::chan_t blend(
        input hsv2rgb_pkg::chan_t c,
        input logic [7:0]         s,
        input logic [14:0]        g
    );
        logic [hsv2rgb_pkg::ChanW+7:0] prod;
        prod = {8'd0, c} * {{hsv2rgb_pkg::ChanW{1'b0}}, s};
        return prod[hsv2rgb_pkg::ChanW+7:8] + {1'b0, g};
    endfunction

    always_comb begin
        sat_inv              = 9'd256 - {1'b0, in_data.saturation};
        grey                 = {sat_inv, 6'd0};
        data_next.brightness = in_data.brightness;
        data_next.chan.r     = blend(in_data.chan.r, in_data.saturation, grey);
        data_next.chan.g     = blend(in_data.chan.g, in_data.saturation, grey);
        data_next.chan.b     = blend(in_data.chan.b, in_data.saturation, grey);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/hsv2rgb_val.sv
// Stage 3: brightness scaling and final 8-bit output register.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_val (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire hsv2rgb_pkg::sat_out_t  in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output hsv2rgb_pkg::rgb_t           out_data
);

    logic               valid_reg;
    hsv2rgb_pkg::rgb_t  data_reg;
    hsv2rgb_pkg::rgb_t  data_next;
    logic               bright_up;
    logic [7:0]         up;
    logic [7:0]         factor;
    logic [14:0]        lift;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // floor(c * f / 128) + lift, then >> 7
    function automatic logic [7:0] scale(
        input hsv2rgb_pkg::chan_t c,
        input logic [7:0]         f,
        input logic [14:0]        l
    );
        logic [hsv2rgb_pkg::ChanW+7:0] prod;
        logic [hsv2rgb_pkg::ChanW:0]   sum;
        prod = {8'd0, c} * {{hsv2rgb_pkg::ChanW{1'b0}}, f};
        sum  = prod[hsv2rgb_pkg::ChanW+7:7] + {2'b0, l};
        return sum[14:7];
    endfunction

    always_comb begin
        bright_up = in_data.brightness > hsv2rgb_pkg::ValMid;
        up        = in_data.brightness - hsv2rgb_pkg::ValMid;
        if (bright_up) begin
            factor = hsv2rgb_pkg::ValMid - up;
            lift   = {up[6:0], 8'd0};
        end else begin
            factor = in_data.brightness;
            lift   = '0;
        end
        data_next.red   = scale(in_data.chan.r, factor, lift);
        data_next.green = scale(in_data.chan.g, factor, lift);
        data_next.blue  = scale(in_data.chan.b, factor, lift);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB pixel pipeline.
//
//  Channel | Dir | Fields (tdata, lowest bit first)
//  --------+-----+------------------------------------------------
//  s_      | in  | hue[7:0], saturation[15:8], brightness[23:16]
//  m_      | out | red[7:0], green[15:8], blue[23:16]
//
// m_tvalid rises once the input transaction has passed the hue ramp,
// saturation and brightness registers in turn; one pixel per cycle
// sustained while m_tready stays high. The three stages (hue ramp multiply,
// saturation multiply, brightness multiply) each hold one pixel register.
// Each stage loads whenever it is empty or its successor takes its pixel,
// so bubbles collapse and a stall on m_tready backs up without loss.
// aresetn (synchronous) clears only the stage valid bits.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // hue, saturation, brightness
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // red, green, blue
);

    // Stage 1 -> 2
    logic                    ramp_valid;
    logic                    ramp_ready;
    hsv2rgb_pkg::ramp_out_t  ramp_data;
    // Stage 2 -> 3
    logic                    sat_valid;
    logic                    sat_ready;
    hsv2rgb_pkg::sat_out_t   sat_data;
    // Stage 3 output register
    hsv2rgb_pkg::rgb_t       rgb;

    hsv2rgb_ramp u_ramp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .hue        (s_tdata[7:0]),
        .saturation (s_tdata[15:8]),
        .brightness (s_tdata[23:16]),
        .out_valid  (ramp_valid),
        .out_ready  (ramp_ready),
        .out_data   (ramp_data)
    );

    hsv2rgb_sat u_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ramp_valid),
        .in_ready  (ramp_ready),
        .in_data   (ramp_data),
        .out_valid (sat_valid),
        .out_ready (sat_ready),
        .out_data  (sat_data)
    );

    hsv2rgb_val u_val (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sat_valid),
        .in_ready  (sat_ready),
        .in_data   (sat_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (rgb)
    );

    // Red in the low byte
    assign m_tdata = {rgb.blue, rgb.green, rgb.red};

endmodule

`default_nettype wire
